[rtl/ottt_pkg.sv]
// ----------------------------------------------------------------------------
// ottt_pkg
// Shared types and constants of the one-time session token table: request
// codes, field widths, the input item and the table request/response groups.
// ----------------------------------------------------------------------------
package ottt_pkg;

  // Field widths
  localparam int TOKEN_W = 64;
  localparam int CTX_W   = 64;
  localparam int SECS_W  = 32;
  localparam int CNT_W   = 32;

  // Packed stream widths
  localparam int IN_TDATA_W  = CTX_W + SECS_W + TOKEN_W;
  localparam int OUT_TDATA_W = TOKEN_W + CTX_W;
  localparam int OUT_TUSER_W = 2;

  // Request codes
  typedef enum logic [0:0] {
    ACT_REGISTER = 1'b0,
    ACT_MATCH    = 1'b1
  } action_t;

  // One input item as held in the input register
  typedef struct packed {
    action_t                     action;
    logic [CTX_W-1:0]            session_context;
    logic [SECS_W-1:0]           time_seconds;
    logic [TOKEN_W-1:0]          lookup_token;
  } in_item_t;

  // Request into the slot table (token is the new token or the lookup token)
  typedef struct packed {
    logic                        en;
    action_t                     action;
    logic [TOKEN_W-1:0]          token;
    logic [CTX_W-1:0]            context_val;
  } tbl_req_t;

  // Response from the slot table
  typedef struct packed {
    logic                        full;
    logic                        hit;
    logic [CTX_W-1:0]            found_context;
  } tbl_resp_t;

endpackage

[rtl/ottt_slot_table.sv]
// ----------------------------------------------------------------------------
// ottt_slot_table
// Slot storage with per-slot token compare, lowest-free-slot priority encode
// and lowest-hit select. Updates the slots when a request is enabled.
// ----------------------------------------------------------------------------
module ottt_slot_table #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ottt_pkg::tbl_req_t  req,
  output ottt_pkg::tbl_resp_t resp
);
  import ottt_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [SLOT_COUNT-1:0] slot_vld_r;
  logic [TOKEN_W-1:0]    slot_tok_r [SLOT_COUNT];
  logic [CTX_W-1:0]      slot_ctx_r [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] match_vec;
  logic [IDX_W-1:0]      free_idx;
  logic                  free_any;
  logic [IDX_W-1:0]      hit_idx;
  logic                  hit_any;
  logic                  do_store;
  logic                  do_free;

  // Compare the token against every slot in parallel
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match_vec[i] = slot_vld_r[i] && (slot_tok_r[i] == req.token);
    end
  end

  // Priority encode: lowest free slot and lowest matching slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    hit_idx  = '0;
    hit_any  = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_vld_r[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
      if (match_vec[i]) begin
        hit_idx = IDX_W'(i);
        hit_any = 1'b1;
      end
    end
  end

  // Build the response for the current request
  always_comb begin
    resp.full          = (req.action == ACT_REGISTER) && !free_any;
    resp.hit           = (req.action == ACT_MATCH) && hit_any;
    resp.found_context = resp.hit ? slot_ctx_r[hit_idx] : '0;
  end

  assign do_store = req.en && (req.action == ACT_REGISTER) && free_any;
  assign do_free  = req.en && (req.action == ACT_MATCH) && hit_any;

  // Track slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else begin
      if (do_store) begin
        slot_vld_r[free_idx] <= 1'b1;
      end
      if (do_free) begin
        slot_vld_r[hit_idx] <= 1'b0;
      end
    end
  end

  // Write token and context into the chosen free slot
  always_ff @(posedge clk) begin
    if (do_store) begin
      slot_tok_r[free_idx] <= req.token;
      slot_ctx_r[free_idx] <= req.context_val;
    end
  end

endmodule

[rtl/one_time_session_token_table_unit.sv]
// ----------------------------------------------------------------------------
// one_time_session_token_table_unit
// One-time session token table: issues tokens on register, finds and frees
// them on match.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one request per transaction: in_tuser selects
//   register (0) or match (1); in_tdata holds the context, the time in
//   seconds and the lookup token. Every request gives exactly one result
//   transaction on the output stream: issued token and matched context in
//   out_tdata, hit and table_full flags in out_tuser.
//   From input acceptance to out_tvalid, the request sits in the input
//   register while the slot compare, free-slot encode and counter update
//   resolve, and the result register loads once it is free.
//   Throughput is one request per cycle while the receiver does not stall,
//   set by the parallel compare over all SLOT_COUNT slots.
//   Reset empties the table and clears the issue counter; no clearing pass.
//   When the receiver stalls, the result is held and one more request is
//   taken into the input register; further input is then back-pressured.
// ----------------------------------------------------------------------------
module one_time_session_token_table_unit #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [63:0] session_context, [95:64] time_seconds, [159:96] lookup_token
  input  logic [ottt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] action
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [63:0] new_token, [127:64] found_context
  output logic [ottt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] hit, [1] table_full
  output logic [ottt_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import ottt_pkg::*;

  logic                   stg_vld_r;
  in_item_t               stg_item_r;
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_nxt;

  logic                   advance;
  logic                   in_take;
  logic [TOKEN_W-1:0]     issue_token;
  logic [TOKEN_W-1:0]     new_token;
  logic                   issued;
  tbl_req_t               req;
  tbl_resp_t              resp;

  // Move the staged request into the result register when it is free
  assign advance   = stg_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !stg_vld_r || advance;
  assign in_take   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_tready) begin
      stg_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_item_r.action          <= action_t'(in_tuser);
      stg_item_r.session_context <= in_tdata[CTX_W-1:0];
      stg_item_r.time_seconds    <= in_tdata[CTX_W+SECS_W-1:CTX_W];
      stg_item_r.lookup_token    <= in_tdata[IN_TDATA_W-1:CTX_W+SECS_W];
    end
  end

  // Build the token and the table request
  assign issue_token = {stg_item_r.time_seconds, cnt_r};

  always_comb begin
    req.en          = advance;
    req.action      = stg_item_r.action;
    req.token       = (stg_item_r.action == ACT_REGISTER) ? issue_token
                                                          : stg_item_r.lookup_token;
    req.context_val = stg_item_r.session_context;
  end

  ottt_slot_table #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_table (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .resp (resp)
  );

  assign issued    = (stg_item_r.action == ACT_REGISTER) && !resp.full;
  assign new_token = issued ? issue_token : '0;

  // Advance the issue counter on every stored token
  assign cnt_nxt = (advance && issued) ? cnt_r + CNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {resp.found_context, new_token};
      out_user_r <= {resp.full, resp.hit};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for one_time_session_token_table_unit. A directed table
// covers the empty, full and one-time cases. Random register/match traffic
// follows, with idle gaps on both streams and one long output stall. Every
// result is compared with a directed expectation or a shadow slot table.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ottt_pkg::*;

  localparam int SLOTS       = 16;
  localparam int PHASE_ITEMS = 283;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_WAIT  = 8;
  localparam int LIMIT       = 200000;
  localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] FILL_SECS = 32'h5A5A_0000;

  // One result transaction as seen on out_tdata / out_tuser
  typedef struct packed {
    logic [TOKEN_W-1:0] new_token;
    logic [CTX_W-1:0]   found_context;
    logic               hit;
    logic               table_full;
  } session_result_t;

  // One directed stimulus row, repeated reps times
  typedef struct {
    action_t            act;
    logic [CTX_W-1:0]   ctx;
    logic [SECS_W-1:0]  secs;
    logic [TOKEN_W-1:0] token;
    int                 reps;
    bit                 known;
    session_result_t    want;
  } stim_row_t;

  localparam int DIR_ROWS = 10;
  stim_row_t dir_rows [DIR_ROWS] = '{
    // miss on the empty table, low and high extremes
    '{ACT_MATCH,    64'h0, 32'h0, 64'h0, 1, 1'b1, '{64'h0, 64'h0, 1'b0, 1'b0}},
    '{ACT_MATCH,    ONES64, 32'hFFFF_FFFF, ONES64, 1, 1'b1,
      '{64'h0, 64'h0, 1'b0, 1'b0}},
    // first tokens carry counter values zero and one
    '{ACT_REGISTER, 64'h0, 32'h0, 64'h0, 1, 1'b1, '{64'h0, 64'h0, 1'b0, 1'b0}},
    '{ACT_REGISTER, ONES64, 32'hFFFF_FFFF, ONES64, 1, 1'b1,
      '{64'hFFFF_FFFF_0000_0001, 64'h0, 1'b0, 1'b0}},
    // hit both, then the same token again must miss
    '{ACT_MATCH,    ONES64, 32'h0, 64'h0, 1, 1'b1, '{64'h0, 64'h0, 1'b1, 1'b0}},
    '{ACT_MATCH,    64'h0, 32'h0, 64'hFFFF_FFFF_0000_0001, 1, 1'b1,
      '{64'h0, ONES64, 1'b1, 1'b0}},
    '{ACT_MATCH,    64'h0, 32'h0, 64'hFFFF_FFFF_0000_0001, 1, 1'b1,
      '{64'h0, 64'h0, 1'b0, 1'b0}},
    // fill every slot, then one more register reports full
    '{ACT_REGISTER, 64'h0123_4567_89AB_CDEF, FILL_SECS, 64'h0, SLOTS, 1'b0,
      '{64'h0, 64'h0, 1'b0, 1'b0}},
    '{ACT_REGISTER, 64'hDEAD_BEEF_0000_FFFF, 32'h1234_5678, 64'h0, 1, 1'b1,
      '{64'h0, 64'h0, 1'b0, 1'b1}},
    // free a middle slot; the next register must reuse it
    '{ACT_MATCH,    64'h0, 32'h0, {FILL_SECS, 32'd7}, 1, 1'b0,
      '{64'h0, 64'h0, 1'b0, 1'b0}}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // Shadow of the slot table and issue counter
  bit                 shadow_valid [SLOTS];
  logic [TOKEN_W-1:0] shadow_token [SLOTS];
  logic [CTX_W-1:0]   shadow_ctx   [SLOTS];
  logic [CNT_W-1:0]   shadow_issue_cnt;
  logic [TOKEN_W-1:0] spent_tokens [$];

  session_result_t pending_results [$];

  int src_idle_pct;
  int dst_idle_pct;
  bit hold_req;
  int cycle_cnt;
  int mismatches;
  int n_register, n_full, n_match, n_hit;

  one_time_session_token_table_unit #(.SLOT_COUNT(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Apply one accepted request to the shadow table and return its result
  function automatic session_result_t serve_request(in_item_t req);
    session_result_t res;
    int slot;
    res = '0;
    slot = -1;
    if (req.action == ACT_REGISTER) begin
      n_register++;
      for (int i = 0; i < SLOTS; i++) begin
        if (!shadow_valid[i] && slot < 0) slot = i;
      end
      if (slot < 0) begin
        res.table_full = 1'b1;
        n_full++;
      end else begin
        res.new_token = {req.time_seconds, shadow_issue_cnt};
        shadow_issue_cnt = shadow_issue_cnt + 1'b1;
        shadow_valid[slot] = 1'b1;
        shadow_token[slot] = res.new_token;
        shadow_ctx[slot]   = req.session_context;
      end
    end else begin
      n_match++;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && shadow_valid[i] && shadow_token[i] == req.lookup_token) slot = i;
      end
      if (slot >= 0) begin
        res.hit = 1'b1;
        res.found_context = shadow_ctx[slot];
        shadow_valid[slot] = 1'b0;
        spent_tokens.push_back(shadow_token[slot]);
        if (spent_tokens.size() > 32) void'(spent_tokens.pop_front());
        n_hit++;
      end
    end
    return res;
  endfunction

  // Offer one request, wait for its transaction, record the expected result
  task automatic offer_request(input in_item_t req, input bit known,
                               input session_result_t want);
    session_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {req.lookup_token, req.time_seconds, req.session_context};
    in_tuser  <= req.action;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = serve_request(req);
    pending_results.push_back(known ? want : res);
  endtask

  // Stop offering until every expected result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle count and timeout
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) @(posedge clk);
    $display("one_time_session_token_table_unit test failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_cnt;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (stall_cnt = 0; stall_cnt < HOLD_CYCLES; stall_cnt++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    session_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata=%h tuser=%b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[63:0] !== exp_res.new_token) begin
          $error("new_token: expected %h, got %h", exp_res.new_token, out_tdata[63:0]);
          mismatches++;
        end
        if (out_tdata[127:64] !== exp_res.found_context) begin
          $error("found_context: expected %h, got %h", exp_res.found_context,
                 out_tdata[127:64]);
          mismatches++;
        end
        if (out_tuser[0] !== exp_res.hit) begin
          $error("hit: expected %b, got %b", exp_res.hit, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[1] !== exp_res.table_full) begin
          $error("table_full: expected %b, got %b", exp_res.table_full, out_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    in_item_t req;
    int src_pcts [3];
    int dst_pcts [3];
    int reg_pct;
    int pick;
    int live [$];
    src_pcts = '{35, 69, 0};
    dst_pcts = '{69, 35, 0};
    mismatches = 0;
    n_register = 0;
    n_full = 0;
    n_match = 0;
    n_hit = 0;
    hold_req = 1'b0;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    shadow_issue_cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_token[i] = '0;
      shadow_ctx[i]   = '0;
    end
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        req.action          = dir_rows[r].act;
        req.session_context = dir_rows[r].ctx;
        req.time_seconds    = dir_rows[r].secs;
        req.lookup_token    = dir_rows[r].token;
        offer_request(req, dir_rows[r].known, dir_rows[r].want);
      end
    end
    req.action          = ACT_REGISTER;
    req.session_context = 64'h8000_0000_0000_0001;
    req.time_seconds    = 32'h8000_0001;
    offer_request(req, 1'b0, '0);
    wait_drained();

    // Random traffic in three idle profiles
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = src_pcts[ph];
      dst_idle_pct = dst_pcts[ph];
      reg_pct = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // shift the register/match mix so the table both fills and drains
        if (n % 40 == 0) begin
          pick = $urandom_range(2);
          reg_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 80;
        end
        // hold the output off while the sender keeps pushing
        if (ph == 2 && n == PHASE_ITEMS / 2) hold_req = 1'b1;
        req.action = ($urandom_range(99) < reg_pct) ? ACT_REGISTER : ACT_MATCH;
        req.session_context = {$urandom, $urandom};
        req.time_seconds    = $urandom;
        live.delete();
        for (int i = 0; i < SLOTS; i++) if (shadow_valid[i]) live.push_back(i);
        pick = $urandom_range(99);
        if (pick < 70 && live.size() > 0)
          req.lookup_token = shadow_token[live[$urandom_range(live.size() - 1)]];
        else if (pick < 85 && spent_tokens.size() > 0)
          req.lookup_token = spent_tokens[$urandom_range(spent_tokens.size() - 1)];
        else
          req.lookup_token = {$urandom, $urandom};
        offer_request(req, 1'b0, '0);
      end
      wait_drained();
    end

    // Let any stray result surface, then report
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d registers (%0d full) and %0d matches (%0d hits)",
             n_register, n_full, n_match, n_hit);
    $display("under three idle profiles and one long output stall");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("one_time_session_token_table_unit test passed");
    end else begin
      $display("one_time_session_token_table_unit test failed");
    end
    $finish;
  end

endmodule
